FILE: src/tls_pkg.sv
`default_nettype none

package tls_pkg;

  // Field widths fixed by the interface
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 1;
  localparam int BRUSH_IN_W  = 7;
  localparam int COLOR_W     = 8;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SURFACE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SURFACE_HEIGHT = 1'b1;

  // Configuration reset values
  localparam logic [CFG_DATA_W-1:0] SURFACE_WIDTH_RESET  = 13'd320;
  localparam logic [CFG_DATA_W-1:0] SURFACE_HEIGHT_RESET = 13'd200;

  // Command codes
  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_t;

  // Walker status toward the result stage
  typedef struct packed {
    logic busy;
    logic fire;
    logic done;
  } walk_status_t;

endpackage

`default_nettype wire

FILE: src/thick_line_stepper_unit.sv
`default_nettype none

// Thick line stepper. A start transaction (func = 0) loads both endpoints, the
// color and the brush side and returns nothing; each following step transaction
// (func = 1) returns the brush square at the current point, clipped to the
// surface, and moves the point one Bresenham step. The square at the end point
// carries done_res and the unit then goes idle; a step while idle returns
// nothing. One transaction may be accepted in every cycle while item_stall is
// low: the Bresenham walker updates its point and error on each accepted step,
// and the clipped square appears in the result register in the cycle after
// the step is accepted. item_stall rises only while a result sits there and
// res_stall holds it. Surface width and height must be written through the
// configuration port only while the unit is idle; the block does not enforce it.
module thick_line_stepper_unit #(
  parameter int COORD_BITS  = 16,
  parameter int MAX_SURFACE = 4096,
  parameter int MAX_BRUSH   = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tls_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [tls_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire logic                                func,
  input  wire logic signed [COORD_BITS-1:0]        start_x,
  input  wire logic signed [COORD_BITS-1:0]        start_y,
  input  wire logic signed [COORD_BITS-1:0]        end_x,
  input  wire logic signed [COORD_BITS-1:0]        end_y,
  input  wire logic [tls_pkg::COLOR_W-1:0]         pen_color,
  input  wire logic [tls_pkg::BRUSH_IN_W-1:0]      brush_size,
  output logic                                     res_valid,
  input  wire logic                                res_stall,
  output logic [$clog2(MAX_SURFACE + 1)-1:0]       x_low,
  output logic [$clog2(MAX_SURFACE + 1)-1:0]       y_low,
  output logic [$clog2(MAX_SURFACE + 1)-1:0]       x_high,
  output logic [$clog2(MAX_SURFACE + 1)-1:0]       y_high,
  output logic                                     empty_res,
  output logic [tls_pkg::COLOR_W-1:0]              fill_color,
  output logic                                     done_res
);

  localparam int BRUSH_W = $clog2(MAX_BRUSH + 1);
  localparam int OUT_W   = $clog2(MAX_SURFACE + 1);

  logic [tls_pkg::CFG_DATA_W-1:0]  surface_width;
  logic [tls_pkg::CFG_DATA_W-1:0]  surface_height;
  logic                            accept;
  tls_pkg::walk_status_t           status;
  logic signed [COORD_BITS-1:0]    pos_x;
  logic signed [COORD_BITS-1:0]    pos_y;
  logic [BRUSH_W-1:0]              brush;
  logic [tls_pkg::COLOR_W-1:0]     color_reg;

  // Stall input only while a held result blocks the result register
  assign item_stall = res_valid && res_stall;
  assign accept     = item_valid && !item_stall;

  tls_cfg_regs u_cfg_regs (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .surface_width  (surface_width),
    .surface_height (surface_height)
  );

  tls_walker #(
    .COORD_BITS (COORD_BITS),
    .MAX_BRUSH  (MAX_BRUSH),
    .BRUSH_W    (BRUSH_W)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .func       (func),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .pen_color  (pen_color),
    .brush_size (brush_size),
    .status     (status),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .brush      (brush),
    .color_reg  (color_reg)
  );

  tls_clip #(
    .COORD_BITS  (COORD_BITS),
    .MAX_SURFACE (MAX_SURFACE),
    .BRUSH_W     (BRUSH_W),
    .OUT_W       (OUT_W)
  ) u_clip (
    .clk            (clk),
    .rst            (rst),
    .status         (status),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .brush          (brush),
    .color_reg      (color_reg),
    .surface_width  (surface_width),
    .surface_height (surface_height),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .x_low          (x_low),
    .y_low          (y_low),
    .x_high         (x_high),
    .y_high         (y_high),
    .empty_res      (empty_res),
    .fill_color     (fill_color),
    .done_res       (done_res)
  );

`ifndef SYNTHESIS
  // The square at the end point ends the line
  assert property (@(posedge clk) disable iff (rst)
    status.fire && status.done |=> !status.busy)
    else $error("walker still busy after the final square");

  // A step while idle produces no result
  assert property (@(posedge clk) disable iff (rst)
    accept && (func == tls_pkg::FUNC_STEP) && !status.busy
      |=> res_valid == $past(res_valid && res_stall))
    else $error("result produced by a step while idle");

  // An empty square reports zero edges
  assert property (@(posedge clk) disable iff (rst)
    res_valid && empty_res |-> (x_low == '0) && (x_high == '0) &&
                              (y_low == '0) && (y_high == '0))
    else $error("empty square with nonzero edges");

  // A non-empty square has positive extent
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !empty_res |-> (x_low < x_high) && (y_low < y_high))
    else $error("non-empty square without extent");
`endif

endmodule

`default_nettype wire

FILE: src/tls_cfg_regs.sv
`default_nettype none

module tls_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tls_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [tls_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic      [tls_pkg::CFG_DATA_W-1:0]      surface_width,
  output logic      [tls_pkg::CFG_DATA_W-1:0]      surface_height
);

  // Always take a write
  assign cfg_ready = 1'b1;

  // Decode the register index and load
  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width  <= tls_pkg::SURFACE_WIDTH_RESET;
      surface_height <= tls_pkg::SURFACE_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tls_pkg::REG_SURFACE_WIDTH:  surface_width  <= cfg_data;
        tls_pkg::REG_SURFACE_HEIGHT: surface_height <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/tls_walker.sv
`default_nettype none

module tls_walker #(
  parameter int COORD_BITS = 16,
  parameter int MAX_BRUSH  = 64,
  parameter int BRUSH_W    = $clog2(MAX_BRUSH + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               accept,
  input  wire logic                               func,
  input  wire logic signed [COORD_BITS-1:0]       start_x,
  input  wire logic signed [COORD_BITS-1:0]       start_y,
  input  wire logic signed [COORD_BITS-1:0]       end_x,
  input  wire logic signed [COORD_BITS-1:0]       end_y,
  input  wire logic [tls_pkg::COLOR_W-1:0]        pen_color,
  input  wire logic [tls_pkg::BRUSH_IN_W-1:0]     brush_size,
  output tls_pkg::walk_status_t                   status,
  output logic signed [COORD_BITS-1:0]            pos_x,
  output logic signed [COORD_BITS-1:0]            pos_y,
  output logic [BRUSH_W-1:0]                      brush,
  output logic [tls_pkg::COLOR_W-1:0]             color_reg
);

  localparam int D_W   = COORD_BITS + 1;
  localparam int ERR_W = COORD_BITS + 3;

  logic                          busy;
  logic signed [COORD_BITS-1:0]  goal_x;
  logic signed [COORD_BITS-1:0]  goal_y;
  logic signed [D_W-1:0]         delta_x;
  logic signed [D_W-1:0]         neg_delta_y;
  logic                          dir_x_neg;
  logic                          dir_y_neg;
  logic signed [ERR_W-1:0]       error_term;

  logic                          start_cmd;
  logic                          done;
  logic signed [D_W-1:0]         diff_x;
  logic signed [D_W-1:0]         diff_y;
  logic signed [D_W-1:0]         abs_x;
  logic signed [D_W-1:0]         abs_y;
  logic [BRUSH_W-1:0]            brush_next;
  logic signed [ERR_W:0]         twice;
  logic                          step_x;
  logic                          step_y;
  logic signed [ERR_W-1:0]       error_term_next;
  logic signed [COORD_BITS-1:0]  pos_x_next;
  logic signed [COORD_BITS-1:0]  pos_y_next;

  assign start_cmd = (func == tls_pkg::FUNC_START);
  assign done      = (pos_x == goal_x) && (pos_y == goal_y);

  assign status.busy = busy;
  assign status.fire = accept && !start_cmd && busy;
  assign status.done = done;

  // Set up the line: absolute deltas and the clamped brush side
  always_comb begin
    diff_x = D_W'(end_x) - D_W'(start_x);
    diff_y = D_W'(end_y) - D_W'(start_y);
    abs_x  = diff_x[D_W-1] ? -diff_x : diff_x;
    abs_y  = diff_y[D_W-1] ? -diff_y : diff_y;
    if (brush_size == '0) begin
      brush_next = BRUSH_W'(1);
    end else if (int'(brush_size) > MAX_BRUSH) begin
      brush_next = BRUSH_W'(MAX_BRUSH);
    end else begin
      brush_next = BRUSH_W'(brush_size);
    end
  end

  // Advance one Bresenham step
  always_comb begin
    twice           = {error_term, 1'b0};
    step_x          = (twice >= (ERR_W + 1)'(neg_delta_y));
    step_y          = (twice <= (ERR_W + 1)'(delta_x));
    error_term_next = error_term
                    + (step_x ? ERR_W'(neg_delta_y) : '0)
                    + (step_y ? ERR_W'(delta_x) : '0);
    pos_x_next      = pos_x;
    pos_y_next      = pos_y;
    if (step_x) begin
      pos_x_next = dir_x_neg ? pos_x - COORD_BITS'(1) : pos_x + COORD_BITS'(1);
    end
    if (step_y) begin
      pos_y_next = dir_y_neg ? pos_y - COORD_BITS'(1) : pos_y + COORD_BITS'(1);
    end
  end

  // Hold busy while a line is in progress
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept && start_cmd) begin
      busy <= 1'b1;
    end else if (status.fire && done) begin
      busy <= 1'b0;
    end
  end

  // Load the line on start, move the point on each step
  always_ff @(posedge clk) begin
    if (accept && start_cmd) begin
      pos_x       <= start_x;
      pos_y       <= start_y;
      goal_x      <= end_x;
      goal_y      <= end_y;
      color_reg   <= pen_color;
      brush       <= brush_next;
      delta_x     <= abs_x;
      neg_delta_y <= -abs_y;
      dir_x_neg   <= !(start_x < end_x);
      dir_y_neg   <= !(start_y < end_y);
      error_term  <= ERR_W'(abs_x) - ERR_W'(abs_y);
    end else if (status.fire && !done) begin
      pos_x      <= pos_x_next;
      pos_y      <= pos_y_next;
      error_term <= error_term_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/tls_clip.sv
`default_nettype none

module tls_clip #(
  parameter int COORD_BITS  = 16,
  parameter int MAX_SURFACE = 4096,
  parameter int BRUSH_W     = 7,
  parameter int OUT_W       = $clog2(MAX_SURFACE + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire tls_pkg::walk_status_t              status,
  input  wire logic signed [COORD_BITS-1:0]       pos_x,
  input  wire logic signed [COORD_BITS-1:0]       pos_y,
  input  wire logic [BRUSH_W-1:0]                 brush,
  input  wire logic [tls_pkg::COLOR_W-1:0]        color_reg,
  input  wire logic [tls_pkg::CFG_DATA_W-1:0]     surface_width,
  input  wire logic [tls_pkg::CFG_DATA_W-1:0]     surface_height,
  output logic                                    res_valid,
  input  wire logic                               res_stall,
  output logic [OUT_W-1:0]                        x_low,
  output logic [OUT_W-1:0]                        y_low,
  output logic [OUT_W-1:0]                        x_high,
  output logic [OUT_W-1:0]                        y_high,
  output logic                                    empty_res,
  output logic [tls_pkg::COLOR_W-1:0]             fill_color,
  output logic                                    done_res
);

  localparam int CFG_W = tls_pkg::CFG_DATA_W;
  localparam int LIM_W = (OUT_W > CFG_W) ? OUT_W : CFG_W;
  localparam int SUM_W = ((COORD_BITS > LIM_W) ? COORD_BITS : LIM_W) + 2;

  logic [OUT_W-1:0]         lim_w;
  logic [OUT_W-1:0]         lim_h;
  logic signed [SUM_W-1:0]  x_start;
  logic signed [SUM_W-1:0]  y_start;
  logic signed [SUM_W-1:0]  x_end;
  logic signed [SUM_W-1:0]  y_end;
  logic [OUT_W-1:0]         xl;
  logic [OUT_W-1:0]         xh;
  logic [OUT_W-1:0]         yl;
  logic [OUT_W-1:0]         yh;
  logic                     empty;
  logic                     res_valid_next;

  function automatic logic [OUT_W-1:0] clamp_lim(input logic signed [SUM_W-1:0] v,
                                                 input logic [OUT_W-1:0] lim);
    logic signed [SUM_W-1:0] lim_s;
    lim_s = $signed(SUM_W'(lim));
    if (v < 0) begin
      return '0;
    end else if (v > lim_s) begin
      return lim;
    end
    return OUT_W'(v);
  endfunction

  // Saturate the surface size at the largest supported surface
  always_comb begin
    lim_w = (LIM_W'(surface_width) > LIM_W'(MAX_SURFACE)) ? OUT_W'(MAX_SURFACE)
                                                          : OUT_W'(surface_width);
    lim_h = (LIM_W'(surface_height) > LIM_W'(MAX_SURFACE)) ? OUT_W'(MAX_SURFACE)
                                                           : OUT_W'(surface_height);
  end

  // Clip the brush square to the surface
  always_comb begin
    x_start = SUM_W'(pos_x);
    y_start = SUM_W'(pos_y);
    x_end   = x_start + $signed(SUM_W'(brush));
    y_end   = y_start + $signed(SUM_W'(brush));
    xl      = clamp_lim(x_start, lim_w);
    xh      = clamp_lim(x_end, lim_w);
    yl      = clamp_lim(y_start, lim_h);
    yh      = clamp_lim(y_end, lim_h);
    empty   = (xh <= xl) || (yh <= yl);
  end

  // Hold the result until it is taken; a new one may replace it in the same cycle
  assign res_valid_next = status.fire || (res_valid && res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (status.fire) begin
      x_low      <= empty ? '0 : xl;
      y_low      <= empty ? '0 : yl;
      x_high     <= empty ? '0 : xh;
      y_high     <= empty ? '0 : yh;
      empty_res  <= empty;
      fill_color <= color_reg;
      done_res   <= status.done;
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb_thick_line_stepper_unit.sv
`timescale 1ns / 1ps

module tb_thick_line_stepper_unit;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int IDLE_PERCENT   = 15;
  localparam int REPORT_LIMIT   = 10;
  localparam int MAX_SIDE       = 4096;
  localparam int MAX_BRUSH_SIDE = 64;
  localparam int EDGE_W         = $clog2(MAX_SIDE + 1);

  // One command as it crosses the item channel
  typedef struct {
    tls_pkg::func_t                 op;
    logic signed [15:0]             sx;
    logic signed [15:0]             sy;
    logic signed [15:0]             ex;
    logic signed [15:0]             ey;
    logic [tls_pkg::COLOR_W-1:0]    color;
    logic [tls_pkg::BRUSH_IN_W-1:0] brush;
  } line_cmd_t;

  // One clipped brush square
  typedef struct packed {
    logic [EDGE_W-1:0]           xl;
    logic [EDGE_W-1:0]           yl;
    logic [EDGE_W-1:0]           xh;
    logic [EDGE_W-1:0]           yh;
    logic                        empty;
    logic [tls_pkg::COLOR_W-1:0] color;
    logic                        done;
  } square_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [tls_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [tls_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic item_valid;
  logic item_stall;
  logic func;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic [tls_pkg::COLOR_W-1:0]    pen_color;
  logic [tls_pkg::BRUSH_IN_W-1:0] brush_size;
  logic res_valid;
  logic res_stall;
  logic [EDGE_W-1:0] x_low;
  logic [EDGE_W-1:0] y_low;
  logic [EDGE_W-1:0] x_high;
  logic [EDGE_W-1:0] y_high;
  logic empty_res;
  logic [tls_pkg::COLOR_W-1:0] fill_color;
  logic done_res;

  // Line walker copy kept by the testbench
  logic [tls_pkg::CFG_DATA_W-1:0] clip_w;
  logic [tls_pkg::CFG_DATA_W-1:0] clip_h;
  bit                             line_busy;
  int                             cur_x, cur_y, goal_x, goal_y;
  int                             span_x, neg_span_y, step_err;
  bit                             walk_x_neg, walk_y_neg;
  int                             brush_side;
  logic [tls_pkg::COLOR_W-1:0]    line_color;

  square_t pending_squares[$];
  square_t got_sq;
  square_t want_sq;
  int      bad_squares;
  int      cycle_count;
  bit      quiet;
  bit      hold_req;

  thick_line_stepper_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .func       (func),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .pen_color  (pen_color),
    .brush_size (brush_size),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .x_low      (x_low),
    .y_low      (y_low),
    .x_high     (x_high),
    .y_high     (y_high),
    .empty_res  (empty_res),
    .fill_color (fill_color),
    .done_res   (done_res)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clamp(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int clip_limit(input logic [tls_pkg::CFG_DATA_W-1:0] r);
    return (int'(r) > MAX_SIDE) ? MAX_SIDE : int'(r);
  endfunction

  function automatic int fit16(input int v);
    return clamp(v, -32768, 32767);
  endfunction

  function automatic int line_points(input line_cmd_t c);
    int dx;
    int dy;
    dx = mag(int'(c.ex) - int'(c.sx));
    dy = mag(int'(c.ey) - int'(c.sy));
    return ((dx > dy) ? dx : dy) + 1;
  endfunction

  function automatic line_cmd_t start_cmd(input int sx, input int sy, input int ex,
                                          input int ey, input int color, input int brush);
    line_cmd_t c;
    c.op    = tls_pkg::FUNC_START;
    c.sx    = 16'(sx);
    c.sy    = 16'(sy);
    c.ex    = 16'(ex);
    c.ey    = 16'(ey);
    c.color = tls_pkg::COLOR_W'(color);
    c.brush = tls_pkg::BRUSH_IN_W'(brush);
    return c;
  endfunction

  // Fill every field with noise; the block ignores the payload of a step
  function automatic line_cmd_t noise_cmd(input tls_pkg::func_t op);
    line_cmd_t c;
    logic [31:0] r0;
    logic [31:0] r1;
    logic [31:0] r2;
    r0 = $urandom;
    r1 = $urandom;
    r2 = $urandom;
    c.op    = op;
    c.sx    = r0[15:0];
    c.sy    = r0[31:16];
    c.ex    = r1[15:0];
    c.ey    = r1[31:16];
    c.color = r2[7:0];
    c.brush = r2[14:8];
    return c;
  endfunction

  // Pick a start near the surface most of the time, anywhere otherwise
  function automatic line_cmd_t random_start();
    logic [31:0] r;
    int sx, sy, span, brush;
    r = $urandom;
    if ($urandom_range(99) < 85) begin
      sx = int'($urandom_range(0, clip_limit(clip_w) + 80)) - 70;
      sy = int'($urandom_range(0, clip_limit(clip_h) + 80)) - 70;
    end else begin
      sx = int'($signed(r[15:0]));
      sy = int'($signed(r[31:16]));
    end
    span = ($urandom_range(99) < 90) ? 12 : 160;
    if ($urandom_range(99) < 85) brush = $urandom_range(1, MAX_BRUSH_SIDE);
    else brush = $urandom_range(0, 127);
    return start_cmd(sx, sy,
                     fit16(sx + int'($urandom_range(0, 2 * span)) - span),
                     fit16(sy + int'($urandom_range(0, 2 * span)) - span),
                     $urandom_range(0, 255), brush);
  endfunction

  function automatic int random_side();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 16) return (1 << tls_pkg::CFG_DATA_W) - 1;
    return $urandom_range(1, MAX_SIDE);
  endfunction

  // Advance the walker copy on one accepted command, queue any square it yields
  task automatic walk_line(input line_cmd_t c, output bit counted);
    square_t sq;
    int w, h, xl, xh, yl, yh, twice, b;
    bit empty, at_goal;
    counted = 1'b1;
    if (c.op == tls_pkg::FUNC_START) begin
      b          = int'(c.brush);
      brush_side = clamp(b, 1, MAX_BRUSH_SIDE);
      cur_x      = c.sx;
      cur_y      = c.sy;
      goal_x     = c.ex;
      goal_y     = c.ey;
      line_color = c.color;
      span_x     = mag(goal_x - cur_x);
      neg_span_y = -mag(goal_y - cur_y);
      walk_x_neg = !(cur_x < goal_x);
      walk_y_neg = !(cur_y < goal_y);
      step_err   = span_x + neg_span_y;
      line_busy  = 1'b1;
    end else if (!line_busy) begin
      counted = 1'b0;
    end else begin
      w  = clip_limit(clip_w);
      h  = clip_limit(clip_h);
      xl = clamp(cur_x, 0, w);
      xh = clamp(cur_x + brush_side, 0, w);
      yl = clamp(cur_y, 0, h);
      yh = clamp(cur_y + brush_side, 0, h);
      empty   = (xh <= xl) || (yh <= yl);
      at_goal = (cur_x == goal_x) && (cur_y == goal_y);
      if (empty) begin
        xl = 0;
        xh = 0;
        yl = 0;
        yh = 0;
      end
      sq.xl    = EDGE_W'(xl);
      sq.yl    = EDGE_W'(yl);
      sq.xh    = EDGE_W'(xh);
      sq.yh    = EDGE_W'(yh);
      sq.empty = empty;
      sq.color = line_color;
      sq.done  = at_goal;
      pending_squares.push_back(sq);
      // Drop the line at its end point, otherwise take one Bresenham step
      if (at_goal) begin
        line_busy = 1'b0;
      end else begin
        twice = 2 * step_err;
        if (twice >= neg_span_y) begin
          step_err += neg_span_y;
          cur_x    += walk_x_neg ? -1 : 1;
        end
        if (twice <= span_x) begin
          step_err += span_x;
          cur_y    += walk_y_neg ? -1 : 1;
        end
      end
    end
  endtask

  // Offer one command after a random gap and hold it until accepted
  task automatic send_cmd(input line_cmd_t c, output bit counted);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    func       <= c.op;
    start_x    <= c.sx;
    start_y    <= c.sy;
    end_x      <= c.ex;
    end_y      <= c.ey;
    pen_color  <= c.color;
    brush_size <= c.brush;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    walk_line(c, counted);
  endtask

  task automatic send_steps(input int n);
    bit counted;
    repeat (n) send_cmd(noise_cmd(tls_pkg::FUNC_STEP), counted);
  endtask

  task automatic write_reg(input logic [tls_pkg::CFG_INDEX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= tls_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == tls_pkg::REG_SURFACE_WIDTH) clip_w = tls_pkg::CFG_DATA_W'(value);
    else clip_h = tls_pkg::CFG_DATA_W'(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Finish any open line, then wait until every square has drained
  task automatic settle_block();
    bit counted;
    if (line_busy) begin
      send_cmd(start_cmd(0, 0, 0, 0, 0, 1), counted);
      send_cmd(noise_cmd(tls_pkg::FUNC_STEP), counted);
    end
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_squares.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_surface(input int w, input int h);
    settle_block();
    write_reg(tls_pkg::REG_SURFACE_WIDTH, w);
    write_reg(tls_pkg::REG_SURFACE_HEIGHT, h);
  endtask

  // Mix mostly whole lines with cut-short lines, stray steps and noise
  task automatic run_lines(input int n);
    line_cmd_t c;
    bit counted;
    int sent, kind, pts, k;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(99);
      c    = random_start();
      pts  = line_points(c);
      if (kind < 75) begin
        send_cmd(c, counted);
        sent += 1 + pts;
        send_steps(pts);
        if ($urandom_range(9) == 0) send_steps(1);
      end else if (kind < 87) begin
        send_cmd(c, counted);
        k = $urandom_range(0, pts - 1);
        sent += 1 + k;
        send_steps(k);
      end else if (kind < 95) begin
        send_cmd(noise_cmd(tls_pkg::FUNC_STEP), counted);
        sent += counted;
      end else begin
        send_cmd(noise_cmd($urandom_range(1) ? tls_pkg::FUNC_STEP : tls_pkg::FUNC_START),
                 counted);
        sent += counted;
      end
    end
  endtask

  task automatic test_idle_step();
    send_steps(1);
  endtask

  task automatic test_single_point();
    bit counted;
    send_cmd(start_cmd(5, 5, 5, 5, 255, 0), counted);
    send_steps(2);
  endtask

  task automatic test_extreme_endpoints();
    bit counted;
    send_cmd(start_cmd(-32768, -32768, 32767, 32767, 0, 127), counted);
    send_steps(3);
    // Restart while the long line is still busy
    send_cmd(start_cmd(0, 0, 3, -2, 8'hA5, 64), counted);
    send_steps(4);
  endtask

  task automatic test_surface_edges();
    bit counted;
    send_cmd(start_cmd(319, 199, 316, 203, 8'h3C, 64), counted);
    send_steps(5);
    send_cmd(start_cmd(-3, -2, -1, 0, 8'hC3, 4), counted);
    send_steps(3);
  endtask

  task automatic test_surface_settings();
    int sides[8][2];
    sides = '{'{1, 1}, '{4096, 4096}, '{8191, 8191}, '{0, 4096},
              '{4096, 0}, '{4097, 13}, '{17, 4095}, '{320, 200}};
    foreach (sides[i]) begin
      set_surface(sides[i][0], sides[i][1]);
      run_lines(120);
    end
  endtask

  task automatic test_input_backpressure();
    bit counted;
    hold_req = 1'b1;
    send_cmd(start_cmd(0, 0, 40, 7, 8'h5A, 3), counted);
    send_steps(41);
    run_lines(60);
  endtask

  task automatic test_random_lines();
    quiet = 1'b1;
    run_lines(250);
    quiet = 1'b0;
    repeat (3) begin
      set_surface(random_side(), random_side());
      run_lines(150);
    end
  endtask

  // Hold the result side idle at random, or for one long stretch on request
  always begin
    @(negedge clk);
    if (hold_req) begin
      res_stall <= 1'b1;
      for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
      hold_req = 1'b0;
    end else if (quiet) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Compare each result transaction with the oldest pending square
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      got_sq = '{x_low, y_low, x_high, y_high, empty_res, fill_color, done_res};
      if (pending_squares.size() == 0) begin
        bad_squares++;
        if (bad_squares <= REPORT_LIMIT)
          $display({"unexpected square: xl=%0d yl=%0d xh=%0d yh=%0d",
                    " empty=%0b color=%0d done=%0b"},
                   got_sq.xl, got_sq.yl, got_sq.xh, got_sq.yh, got_sq.empty,
                   got_sq.color, got_sq.done);
      end else begin
        want_sq = pending_squares.pop_front();
        if (got_sq.xl !== want_sq.xl || got_sq.yl !== want_sq.yl ||
            got_sq.xh !== want_sq.xh || got_sq.yh !== want_sq.yh ||
            got_sq.empty !== want_sq.empty || got_sq.color !== want_sq.color ||
            got_sq.done !== want_sq.done) begin
          bad_squares++;
          if (bad_squares <= REPORT_LIMIT) begin
            $display({"square mismatch: want xl=%0d yl=%0d xh=%0d yh=%0d",
                      " empty=%0b color=%0d done=%0b"},
                     want_sq.xl, want_sq.yl, want_sq.xh, want_sq.yh, want_sq.empty,
                     want_sq.color, want_sq.done);
            $display({"                  got xl=%0d yl=%0d xh=%0d yh=%0d",
                      " empty=%0b color=%0d done=%0b"},
                     got_sq.xl, got_sq.yl, got_sq.xh, got_sq.yh, got_sq.empty,
                     got_sq.color, got_sq.done);
          end
        end
      end
    end
  end

  // End the run if it hangs
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("thick_line_stepper_unit verification failed");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    item_valid  = 1'b0;
    func        = tls_pkg::FUNC_START;
    start_x     = '0;
    start_y     = '0;
    end_x       = '0;
    end_y       = '0;
    pen_color   = '0;
    brush_size  = '0;
    res_stall   = 1'b0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    bad_squares = 0;
    clip_w      = tls_pkg::SURFACE_WIDTH_RESET;
    clip_h      = tls_pkg::SURFACE_HEIGHT_RESET;
    line_busy   = 1'b0;
    cur_x       = 0;
    cur_y       = 0;
    goal_x      = 0;
    goal_y      = 0;
    span_x      = 0;
    neg_span_y  = 0;
    step_err    = 0;
    walk_x_neg  = 1'b0;
    walk_y_neg  = 1'b0;
    brush_side  = 1;
    line_color  = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    test_idle_step();
    test_single_point();
    test_extreme_endpoints();
    test_surface_edges();
    test_surface_settings();
    test_input_backpressure();
    test_random_lines();
    settle_block();

    if (bad_squares == 0 && pending_squares.size() == 0) begin
      $display("thick_line_stepper_unit verification clean");
    end else begin
      $display("thick_line_stepper_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/tls_pkg.sv
src/tls_cfg_regs.sv
src/tls_walker.sv
src/tls_clip.sv
src/thick_line_stepper_unit.sv
sim/tb_thick_line_stepper_unit.sv
